// ----- hdl/pbd_pkg.sv -----
// Shared types and constants of the PackBits line decoder.
package pbd_pkg;

  // Width of the output byte counter and of the stored line length.
  localparam int unsigned LineCountBits = 16;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntBits = $clog2(QueueDepth + 1);

  // Header class of a source byte, worked out in the front.
  typedef enum logic [1:0] {
    KindLiteral = 2'd0,
    KindRun     = 2'd1,
    KindNop     = 2'd2
  } kind_e;

  // One classified source byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    kind_e      kind;
    logic [7:0] count;   // literal or run length if the byte is a header
  } item_t;

  // Queue fill status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- hdl/pbd_front.sv -----
// Input stage: accepts source bytes and classifies them as headers.
module pbd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            in_byte_i,
  input  logic                  last_of_line_i,
  input  pbd_pkg::queue_status_t q_status_i,
  output logic                  push_o,
  output pbd_pkg::item_t        push_item_o
);

  logic           valid_q, valid_d;
  pbd_pkg::item_t item_q, item_d;
  logic           accept;
  logic [8:0]     run_cnt;

  assign push_o      = valid_q && !q_status_i.full;
  assign in_stall_o  = valid_q && q_status_i.full;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_item_o = item_q;

  // Run length is 1 - n for the signed header n, i.e. 257 - byte.
  assign run_cnt = 9'd257 - {1'b0, in_byte_i};

  always_comb begin
    item_d      = item_q;
    item_d.data = in_byte_i;
    item_d.last = last_of_line_i;
    if (!in_byte_i[7]) begin
      item_d.kind  = pbd_pkg::KindLiteral;
      item_d.count = in_byte_i + 8'd1;
    end else if (in_byte_i == 8'h80) begin
      item_d.kind  = pbd_pkg::KindNop;
      item_d.count = 8'd0;
    end else begin
      item_d.kind  = pbd_pkg::KindRun;
      item_d.count = run_cnt[7:0];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ----- hdl/pbd_queue.sv -----
// Short FIFO of classified items between the front and the back.
module pbd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pbd_pkg::item_t         push_item_i,
  input  logic                   pop_i,
  output pbd_pkg::item_t         head_o,
  output pbd_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = pbd_pkg::QueuePtrBits;
  localparam int unsigned CntW = pbd_pkg::QueueCntBits;

  pbd_pkg::item_t mem_q [pbd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CntW'(pbd_pkg::QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(pbd_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(pbd_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- hdl/pbd_back.sv -----
// Decode stage: line state machine, line length register and result register.
module pbd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  pbd_pkg::queue_status_t q_status_i,
  input  pbd_pkg::item_t        head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  byte_valid_o,
  output logic [7:0]            out_byte_o,
  output logic [7:0]            repeat_count_o,
  output logic                  line_done_o,
  output logic                  line_ok_o
);

  localparam int unsigned LcW = pbd_pkg::LineCountBits;

  typedef enum logic [2:0] {
    PhHeader  = 3'b001,
    PhLiteral = 3'b010,
    PhRun     = 3'b100
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [7:0]     remaining_q, remaining_d;
  logic [7:0]     run_length_q, run_length_d;
  logic [LcW-1:0] produced_q, produced_d;
  logic           failed_q, failed_d;
  logic [LcW-1:0] line_length_q;

  logic           out_valid_q;
  logic           byte_valid_q, line_done_q, line_ok_q;
  logic [7:0]     out_byte_q, repeat_count_q;

  logic           emit, ok, has_result;
  logic [7:0]     ecount;
  logic [LcW:0]   need;

  assign pop_o      = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign need       = {1'b0, produced_q} + (LcW + 1)'(head_i.count);
  assign has_result = emit || head_i.last;

  always_comb begin
    phase_d      = phase_q;
    remaining_d  = remaining_q;
    run_length_d = run_length_q;
    produced_d   = produced_q;
    failed_d     = failed_q;
    emit         = 1'b0;
    ecount       = 8'd0;
    ok           = 1'b0;
    if (!failed_q) begin
      case (phase_q)
        PhHeader: begin
          if (produced_q < line_length_q) begin
            case (head_i.kind)
              pbd_pkg::KindLiteral: begin
                if (need > {1'b0, line_length_q}) begin
                  failed_d = 1'b1;
                end else begin
                  remaining_d = head_i.count;
                  phase_d     = PhLiteral;
                end
              end
              pbd_pkg::KindRun: begin
                if (need > {1'b0, line_length_q}) begin
                  failed_d = 1'b1;
                end else begin
                  run_length_d = head_i.count;
                  phase_d      = PhRun;
                end
              end
              default: begin
              end
            endcase
          end
        end
        PhLiteral: begin
          emit        = 1'b1;
          ecount      = 8'd1;
          produced_d  = produced_q + 1'b1;
          remaining_d = remaining_q - 8'd1;
          if (remaining_d == 8'd0) begin
            phase_d = PhHeader;
          end
        end
        PhRun: begin
          emit         = 1'b1;
          ecount       = run_length_q;
          produced_d   = produced_q + LcW'(run_length_q);
          run_length_d = 8'd0;
          phase_d      = PhHeader;
        end
        default: begin
          phase_d = PhHeader;
        end
      endcase
    end
    if (head_i.last) begin
      if (phase_d != PhHeader) begin
        failed_d = 1'b1;
      end
      ok           = !failed_d && (produced_d == line_length_q);
      // Clear the line state for the next scanline.
      phase_d      = PhHeader;
      remaining_d  = 8'd0;
      run_length_d = 8'd0;
      produced_d   = '0;
      failed_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHeader;
      remaining_q  <= 8'd0;
      run_length_q <= 8'd0;
      produced_q   <= '0;
      failed_q     <= 1'b0;
    end else if (pop_o) begin
      phase_q      <= phase_d;
      remaining_q  <= remaining_d;
      run_length_q <= run_length_d;
      produced_q   <= produced_d;
      failed_q     <= failed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= LcW'(1);
    end else if (cfg_we_i) begin
      line_length_q <= LcW'(cfg_wdata_i);
    end
  end

  // Result register: load a new transaction on pop, drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= has_result;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && has_result) begin
      byte_valid_q   <= emit;
      out_byte_q     <= emit ? head_i.data : 8'd0;
      repeat_count_q <= ecount;
      line_done_q    <= head_i.last;
      line_ok_q      <= ok;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_valid_o   = byte_valid_q;
  assign out_byte_o     = out_byte_q;
  assign repeat_count_o = repeat_count_q;
  assign line_done_o    = line_done_q;
  assign line_ok_o      = line_ok_q;

endmodule

// ----- hdl/packbits_line_decoder_core.sv -----
// A source byte passes the front register (loaded at acceptance), a queue entry and the result
// register; an output stall holds it back. Throughput: one source byte per cycle while the
// queue has room; the back retires one queue entry per cycle unless the output stalls.
// A run leaves as one transaction of byte plus repeat count.
// Reset (rst_ni low, asynchronous): queue emptied, line state cleared, line length 1.
// No clearing pass: the block takes bytes in the first cycle after reset.
module packbits_line_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // line length register
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // compressed source bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_of_line_i,
  // decoded results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        byte_valid_o,
  output logic [7:0]  out_byte_o,
  output logic [7:0]  repeat_count_o,
  output logic        line_done_o,
  output logic        line_ok_o
);

  // Front to queue: one classified byte per push.
  logic                   push;
  pbd_pkg::item_t         push_item;
  // Queue to back: head entry and fill status.
  logic                   pop;
  pbd_pkg::item_t         head;
  pbd_pkg::queue_status_t q_status;

  // Front: register each source byte and decode its header class (literal,
  // run or no-op) and its length, so the back needs only one add and two compares per header.
  pbd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .last_of_line_i (last_of_line_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  // Queue: decouples the input stall from the output stall.
  pbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // Back: advance the line state on every popped entry; bytes that produce
  // nothing (headers, ignored bytes) retire without a transaction unless they end the line.
  pbd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_status_i     (q_status),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_valid_o   (byte_valid_o),
    .out_byte_o     (out_byte_o),
    .repeat_count_o (repeat_count_o),
    .line_done_o    (line_done_o),
    .line_ok_o      (line_ok_o)
  );

`ifndef ASSERT_OFF
  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("queue overflow");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("queue underflow");

  // A transaction without a decoded byte is always a line end.
  a_empty_is_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> line_done_o)
    else $error("result without byte or line end");

  // Repeat count is nonzero exactly when a byte is carried.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_valid_o == (repeat_count_o != 8'd0)))
    else $error("repeat count does not match byte valid");

  // Success is only reported at line end.
  a_ok_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_ok_o) |-> line_done_o)
    else $error("line ok outside line end");
`endif

endmodule
